// ----- rtl/mpb_pkg.sv -----
// Package for the path bounding box block: beat widths, register indexes and
// saturating offset / min / max helpers. No dependencies.
package mpb_pkg;

    localparam int COORD_W   = 32;
    localparam int HW_W      = 30;
    localparam int WIDTH_W   = 31;
    localparam int TYPE_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 128;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [1:0] seen_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATH_WIDTH = 2'd0,
        REG_PATH_TYPE  = 2'd1
    } cfg_reg_t;

    // v + hw or v - hw, clamped to the signed 32-bit range
    function automatic coord_t sat_off(input coord_t v, input logic [HW_W-1:0] hw,
                                       input logic sub);
        logic signed [COORD_W:0] s;
        coord_t r;
        if (sub)
            s = {v[COORD_W-1], v} - $signed({3'b000, hw});
        else
            s = {v[COORD_W-1], v} + $signed({3'b000, hw});
        if (s[COORD_W] != s[COORD_W-1])
            r = s[COORD_W] ? COORD_MIN : COORD_MAX;
        else
            r = s[COORD_W-1:0];
        return r;
    endfunction

    function automatic coord_t smin(input coord_t a, input coord_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic coord_t smax(input coord_t a, input coord_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ----- rtl/manhattan_path_bbox.sv -----
// Bounding box of a Manhattan layout path, one vertex per beat.
// Depends on mpb_pkg (widths, register indexes, saturating helpers).

// The block takes path vertices in order, one beat each, and on the beat with
// s_tlast set delivers one result beat holding the box: lower left corner and
// its width and height (upper right minus lower left, modulo 2^32). m_tuser is
// the ok flag: it is low, and m_tdata is all zeros, when the path had fewer
// than two vertices or path_width is zero. Each segment widens the box by
// path_width/2 around the current vertex: in X when the segment's two X values
// match, in Y otherwise. A nonzero path_type also pushes both path ends out by
// path_width/2 along their end segments. Widened coordinates saturate to the
// signed 32-bit range. After the last vertex all path state clears; the
// registers keep their values. A vertex beat is registered on input and
// folded into the running box from that register, so one beat is taken per
// cycle while the input stage is not stalled; the saturating offsets, the
// four-way min/max compare tree and the box subtraction behind it form the
// critical path. A full result register lets vertex beats keep flowing; only
// a second last vertex waits for the result to be taken. Write configuration
// only while no path is in flight; cfg_ready is always high.
module manhattan_path_bbox
    import mpb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // vertex stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] point_x, [63:32] point_y
    input  logic                  s_tlast,   // last_point
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [31:0] box_x, [63:32] box_y, [95:64] box_w, [127:96] box_h
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser,   // ok
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [WIDTH_W-1:0]    cfg_data
);

    // configuration
    logic [WIDTH_W-1:0] path_width_reg;
    logic [TYPE_W-1:0]  path_type_reg;

    // input stage
    logic   in_valid_reg;
    coord_t in_x_reg, in_y_reg;
    logic   in_last_reg;

    // path state
    coord_t min_x_reg, min_y_reg, max_x_reg, max_y_reg;
    coord_t prev_x_reg, prev_y_reg;
    coord_t head0_x_reg, head0_y_reg, head1_x_reg, head1_y_reg;
    seen_t  seen_reg;

    // result stage
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_ok_reg;

    logic s_fire, step_go, step_fire;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            path_width_reg <= '0;
            path_type_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PATH_WIDTH: path_width_reg <= cfg_data;
                REG_PATH_TYPE:  path_type_reg  <= cfg_data[TYPE_W-1:0];
                default:        ;
            endcase
        end
    end

    // Handshake: a vertex that is not last never waits; a last one waits for
    // the result register to free up.
    assign step_go   = !in_last_reg || !out_valid_reg || m_tready;
    assign step_fire = in_valid_reg && step_go;
    assign s_tready  = !in_valid_reg || step_go;
    assign s_fire    = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_fire)
            in_valid_reg <= 1'b1;
        else if (step_fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_x_reg    <= s_tdata[COORD_W-1:0];
            in_y_reg    <= s_tdata[2*COORD_W-1:COORD_W];
            in_last_reg <= s_tlast;
        end
    end

    // Candidate bounds for this vertex.
    logic [HW_W-1:0] hw;
    logic   seen_any, seg_vert, seg_horz, ok, ext;
    coord_t h1x, h1y;
    coord_t x_lo, x_hi, y_lo, y_hi, h0x_lo, h0x_hi, h0y_lo, h0y_hi;
    logic   st_vert, en_vert;
    coord_t c_minx_a, c_minx_b, c_minx_c;
    coord_t c_maxx_a, c_maxx_b, c_maxx_c;
    coord_t c_miny_a, c_miny_b, c_miny_c;
    coord_t c_maxy_a, c_maxy_b, c_maxy_c;
    coord_t min_x_next, min_y_next, max_x_next, max_y_next;

    always_comb
    begin
        hw       = path_width_reg[WIDTH_W-1:1];
        seen_any = (seen_reg != 2'd0);
        seg_vert = seen_any && (prev_x_reg == in_x_reg);
        seg_horz = seen_any && (prev_x_reg != in_x_reg);
        ok       = in_last_reg && seen_any && (path_width_reg != '0);
        ext      = ok && (path_type_reg != '0);

        // second vertex may be the one in hand
        h1x = (seen_reg == 2'd1) ? in_x_reg : head1_x_reg;
        h1y = (seen_reg == 2'd1) ? in_y_reg : head1_y_reg;

        x_lo   = sat_off(in_x_reg, hw, 1'b1);
        x_hi   = sat_off(in_x_reg, hw, 1'b0);
        y_lo   = sat_off(in_y_reg, hw, 1'b1);
        y_hi   = sat_off(in_y_reg, hw, 1'b0);
        h0x_lo = sat_off(head0_x_reg, hw, 1'b1);
        h0x_hi = sat_off(head0_x_reg, hw, 1'b0);
        h0y_lo = sat_off(head0_y_reg, hw, 1'b1);
        h0y_hi = sat_off(head0_y_reg, hw, 1'b0);

        st_vert = (head0_x_reg == h1x);
        en_vert = (in_x_reg == prev_x_reg);

        // segment widening
        c_minx_a = seg_vert ? x_lo : in_x_reg;
        c_maxx_a = seg_vert ? x_hi : in_x_reg;
        c_miny_a = seg_horz ? y_lo : in_y_reg;
        c_maxy_a = seg_horz ? y_hi : in_y_reg;

        // start end extension
        c_minx_b = (ext && !st_vert && head0_x_reg < h1x) ? h0x_lo : COORD_MAX;
        c_maxx_b = (ext && !st_vert && head0_x_reg > h1x) ? h0x_hi : COORD_MIN;
        c_miny_b = (ext && st_vert && head0_y_reg < h1y) ? h0y_lo : COORD_MAX;
        c_maxy_b = (ext && st_vert && head0_y_reg >= h1y) ? h0y_hi : COORD_MIN;

        // finish end extension
        c_minx_c = (ext && !en_vert && in_x_reg < prev_x_reg) ? x_lo : COORD_MAX;
        c_maxx_c = (ext && !en_vert && in_x_reg > prev_x_reg) ? x_hi : COORD_MIN;
        c_miny_c = (ext && en_vert && in_y_reg < prev_y_reg) ? y_lo : COORD_MAX;
        c_maxy_c = (ext && en_vert && in_y_reg >= prev_y_reg) ? y_hi : COORD_MIN;

        min_x_next = smin(smin(min_x_reg, c_minx_a), smin(c_minx_b, c_minx_c));
        max_x_next = smax(smax(max_x_reg, c_maxx_a), smax(c_maxx_b, c_maxx_c));
        min_y_next = smin(smin(min_y_reg, c_miny_a), smin(c_miny_b, c_miny_c));
        max_y_next = smax(smax(max_y_reg, c_maxy_a), smax(c_maxy_b, c_maxy_c));
    end

    // Path state: fold in a vertex, clear after the last one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg   <= COORD_MAX;
            min_y_reg   <= COORD_MAX;
            max_x_reg   <= COORD_MIN;
            max_y_reg   <= COORD_MIN;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            head0_x_reg <= '0;
            head0_y_reg <= '0;
            head1_x_reg <= '0;
            head1_y_reg <= '0;
            seen_reg    <= 2'd0;
        end
        else if (step_fire)
        begin
            if (in_last_reg)
            begin
                min_x_reg   <= COORD_MAX;
                min_y_reg   <= COORD_MAX;
                max_x_reg   <= COORD_MIN;
                max_y_reg   <= COORD_MIN;
                prev_x_reg  <= '0;
                prev_y_reg  <= '0;
                head0_x_reg <= '0;
                head0_y_reg <= '0;
                head1_x_reg <= '0;
                head1_y_reg <= '0;
                seen_reg    <= 2'd0;
            end
            else
            begin
                min_x_reg  <= min_x_next;
                min_y_reg  <= min_y_next;
                max_x_reg  <= max_x_next;
                max_y_reg  <= max_y_next;
                prev_x_reg <= in_x_reg;
                prev_y_reg <= in_y_reg;
                if (seen_reg == 2'd0)
                begin
                    head0_x_reg <= in_x_reg;
                    head0_y_reg <= in_y_reg;
                end
                if (seen_reg == 2'd1)
                begin
                    head1_x_reg <= in_x_reg;
                    head1_y_reg <= in_y_reg;
                end
                if (seen_reg != 2'd2)
                    seen_reg <= seen_reg + 2'd1;
            end
        end
    end

    // Result register.
    logic result_load;
    logic [COORD_W-1:0] box_w, box_h;

    assign result_load = step_fire && in_last_reg;
    assign box_w = max_x_next - min_x_next;
    assign box_h = max_y_next - min_y_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (result_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            out_ok_reg   <= ok;
            out_data_reg <= ok ? {box_h, box_w, min_y_next, min_x_next} : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ok_reg;

`ifndef SYNTHESIS
    a_bad_box_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("invalid box carries nonzero data");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && in_last_reg |=> seen_reg == 2'd0 && min_x_reg == COORD_MAX)
        else $error("path state not cleared after last vertex");

    a_seen_sat: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg != 2'd3)
        else $error("vertex count past saturation");

    a_stall_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !step_go |-> in_last_reg && out_valid_reg && !m_tready)
        else $error("input stage stalled without a pending result");

    a_ok_needs_width: assert property (@(posedge clk) disable iff (!rst_n)
        result_load && ok |-> path_width_reg != '0 && seen_reg != 2'd0)
        else $error("box flagged valid without width or two vertices");
`endif

endmodule
